[hw/rtl/xscs_pkg.sv]
// Shared types, constants and helpers for the XML stream character sanitizer.
package xscs_pkg;

	// Code units that steer tag and quote tracking.
	localparam logic [15:0] CU_LT   = 16'h003C;
	localparam logic [15:0] CU_GT   = 16'h003E;
	localparam logic [15:0] CU_APOS = 16'h0027;
	localparam logic [15:0] CU_QUOT = 16'h0022;
	localparam logic [15:0] CU_AMP  = 16'h0026;
	localparam logic [15:0] CU_G    = 16'h0067;
	localparam logic [15:0] CU_T    = 16'h0074;
	localparam logic [15:0] CU_SEMI = 16'h003B;

	// Bounds of the valid character ranges and the surrogate ranges.
	localparam logic [15:0] CU_TAB      = 16'h0009;
	localparam logic [15:0] CU_LF       = 16'h000A;
	localparam logic [15:0] CU_CR       = 16'h000D;
	localparam logic [15:0] CU_SPACE    = 16'h0020;
	localparam logic [15:0] CU_BMP_LO_HI = 16'hD7FF;
	localparam logic [15:0] CU_BMP_HI_LO = 16'hE000;
	localparam logic [15:0] CU_BMP_HI_HI = 16'hFFFD;
	localparam logic [15:0] CU_HSUR_LO  = 16'hD800;
	localparam logic [15:0] CU_HSUR_HI  = 16'hDBFF;
	localparam logic [15:0] CU_LSUR_LO  = 16'hDC00;
	localparam logic [15:0] CU_LSUR_HI  = 16'hDFFF;

	// Depth of the command queue between front and back.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// One input item.
	typedef struct packed {
		logic [15:0] code_unit;
		logic        end_of_string;
	} in_item_t;

	// One result item.
	typedef struct packed {
		logic [15:0] out_unit;
		logic        last_of_run;
	} out_item_t;

	// What the back part has to emit for one input item.
	typedef enum logic [1:0] {
		CMD_SINGLE,
		CMD_PAIR,
		CMD_ESCAPE
	} cmd_kind_t;

	// Queue entry from front to back.
	typedef struct packed {
		cmd_kind_t   kind;
		logic [15:0] unit_a;
		logic [15:0] unit_b;
	} cmd_t;

	// Units of the '&gt;' replacement, in order.
	function automatic logic [15:0] esc_unit(input logic [1:0] idx);
		logic [15:0] u;
		case (idx)
			2'd0:    u = CU_AMP;
			2'd1:    u = CU_G;
			2'd2:    u = CU_T;
			default: u = CU_SEMI;
		endcase
		return u;
	endfunction

endpackage

[hw/rtl/xml_stream_char_sanitizer_core.sv]
// Top level of the XML stream character sanitizer.
//
// Input channel unit_valid/unit_stall/unit_item carries one UTF-16 code unit
// per item with an end-of-string flag. Output channel res_valid/res_stall/
// res_item carries sanitized code units; last_of_run marks the final result
// caused by one input item. An input item produces zero to four results.
// An item is accepted at a rising edge with valid high and stall low.
// The first result of an item passes through the command queue and then the
// output register before it is offered on the port. One input item is taken
// per cycle while unit_stall is low; the back part emits the results of an
// item one after another, so an item that expands to '&gt;' or to a surrogate
// pair occupies it longer. A four-entry command queue between front and back
// absorbs such bursts; unit_stall rises only when that queue is full. When the
// receiver stalls, the output register holds its item and the queue fills,
// after which the input is stalled. Asynchronous reset clears the tag, quote
// and held-surrogate state, empties the queue and drops res_valid.
module xml_stream_char_sanitizer_core import xscs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      unit_valid,
	output logic      unit_stall,
	input  in_item_t  unit_item,
	output logic      res_valid,
	input  logic      res_stall,
	output out_item_t res_item
);

	logic q_full;
	logic q_push;
	cmd_t q_cmd;
	logic q_pop;
	logic q_not_empty;
	cmd_t q_head;

	// Classification and state tracking.
	xscs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.unit_valid (unit_valid),
		.unit_stall (unit_stall),
		.unit_item  (unit_item),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_cmd      (q_cmd)
	);

	// Command queue.
	xscs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (q_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	// Result expansion.
	xscs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_not_empty),
		.cmd       (q_head),
		.cmd_pop   (q_pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item)
	);

endmodule

[hw/rtl/xscs_front.sv]
// Front part: accepts input items, tracks tag and quote state, and issues commands.
module xscs_front import xscs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     unit_valid,
	output logic     unit_stall,
	input  in_item_t unit_item,
	input  logic     q_full,
	output logic     q_push,
	output cmd_t     q_cmd
);

	logic        in_tag_q;
	logic        in_quote_q;
	logic        quote_dbl_q;
	logic        held_valid_q;
	logic [15:0] held_unit_q;

	logic [15:0] u;
	logic        eos;
	logic        accept;
	logic        is_xml;
	logic        is_high;
	logic        is_low;
	logic        pair;
	logic        nxt_tag;
	logic        nxt_quote;
	logic        nxt_dbl;
	logic        escape;
	logic        emit;
	logic        hold;

	assign u          = unit_item.code_unit;
	assign eos        = unit_item.end_of_string;
	assign unit_stall = q_full;
	assign accept     = unit_valid && !q_full;

	// Character classes.
	always_comb begin
		is_xml = (u == CU_TAB) || (u == CU_LF) || (u == CU_CR)
			|| ((u >= CU_SPACE) && (u <= CU_BMP_LO_HI))
			|| ((u >= CU_BMP_HI_LO) && (u <= CU_BMP_HI_HI));
		is_high = (u >= CU_HSUR_LO) && (u <= CU_HSUR_HI);
		is_low  = (u >= CU_LSUR_LO) && (u <= CU_LSUR_HI);
	end

	// Next tag and quote state, and the decision for this item.
	always_comb begin
		pair      = held_valid_q && is_low;
		nxt_tag   = in_tag_q;
		nxt_quote = in_quote_q;
		nxt_dbl   = quote_dbl_q;
		escape    = 1'b0;
		if (!pair) begin
			if (u == CU_LT) begin
				nxt_tag = 1'b1;
			end else if (u == CU_GT) begin
				if (in_quote_q || !in_tag_q) begin
					escape = 1'b1;
				end else begin
					nxt_tag = 1'b0;
				end
			end else if ((u == CU_APOS) || (u == CU_QUOT)) begin
				if (in_tag_q) begin
					if (!in_quote_q) begin
						nxt_quote = 1'b1;
						nxt_dbl   = (u == CU_QUOT);
					end else if (quote_dbl_q == (u == CU_QUOT)) begin
						nxt_quote = 1'b0;
					end
				end
			end
		end
		emit = pair || escape || (nxt_tag && !nxt_quote) || is_xml;
		hold = !emit && is_high && !eos;
	end

	// Command towards the queue.
	always_comb begin
		q_push       = accept && emit;
		q_cmd.unit_a = held_unit_q;
		q_cmd.unit_b = u;
		if (pair) begin
			q_cmd.kind = CMD_PAIR;
		end else if (escape) begin
			q_cmd.kind = CMD_ESCAPE;
		end else begin
			q_cmd.kind = CMD_SINGLE;
		end
	end

	// Stream state; end of string clears it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_tag_q     <= 1'b0;
			in_quote_q   <= 1'b0;
			quote_dbl_q  <= 1'b0;
			held_valid_q <= 1'b0;
		end else if (accept) begin
			if (eos) begin
				in_tag_q     <= 1'b0;
				in_quote_q   <= 1'b0;
				quote_dbl_q  <= 1'b0;
				held_valid_q <= 1'b0;
			end else begin
				in_tag_q     <= nxt_tag;
				in_quote_q   <= nxt_quote;
				quote_dbl_q  <= nxt_dbl;
				held_valid_q <= hold;
			end
		end
	end

	// Held high surrogate.
	always_ff @(posedge clk) begin
		if (accept && hold) begin
			held_unit_q <= u;
		end
	end

endmodule

[hw/rtl/xscs_queue.sv]
// Short command queue that decouples the front part from the back part.
module xscs_queue import xscs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic not_empty,
	output cmd_t head
);

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_pop;

	assign full      = (count_q == QCNT_W'(QDEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];
	assign do_pop    = pop && not_empty;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

[hw/rtl/xscs_back.sv]
// Back part: expands each command into result items behind an output register.
module xscs_back import xscs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	input  cmd_t      cmd,
	output logic      cmd_pop,
	output logic      res_valid,
	input  logic      res_stall,
	output out_item_t res_item
);

	logic [1:0]  step_q;
	logic        res_valid_q;
	out_item_t   res_item_q;
	logic        advance;
	logic        last;
	logic [15:0] unit;

	assign advance   = cmd_valid && (!res_valid_q || !res_stall);
	assign cmd_pop   = advance && last;
	assign res_valid = res_valid_q;
	assign res_item  = res_item_q;

	// Unit for the current step and whether it ends the run.
	always_comb begin
		case (cmd.kind)
			CMD_PAIR: begin
				unit = (step_q == 2'd0) ? cmd.unit_a : cmd.unit_b;
				last = (step_q == 2'd1);
			end
			CMD_ESCAPE: begin
				unit = esc_unit(step_q);
				last = (step_q == 2'd3);
			end
			default: begin
				unit = cmd.unit_b;
				last = 1'b1;
			end
		endcase
	end

	// Step counter and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				step_q      <= last ? 2'd0 : step_q + 2'd1;
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			res_item_q.out_unit    <= unit;
			res_item_q.last_of_run <= last;
		end
	end

endmodule

[hw/rtl/xscs_checker.sv]
// Port-level checker for the XML stream character sanitizer, bound to the top level.
module xscs_checker import xscs_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      res_valid,
	input logic      res_stall,
	input out_item_t res_item
);

	// A stalled result item stays offered and unchanged.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_item))
	else $error("stalled result item changed or was withdrawn");

	// Results of one input item follow each other without a gap.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_stall && !res_item.last_of_run |=> res_valid)
	else $error("gap inside a run of results");

	// Within an escape, a non-final 'g' is always followed by 't'.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_stall && !res_item.last_of_run && (res_item.out_unit == CU_G)
		|=> res_item.out_unit == CU_T)
	else $error("broken escape sequence");

	// A non-final '&' starts an escape, so 'g' comes next.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_stall && !res_item.last_of_run && (res_item.out_unit == CU_AMP)
		|=> res_item.out_unit == CU_G)
	else $error("escape does not continue with g");

endmodule

bind xml_stream_char_sanitizer_core xscs_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (res_valid),
	.res_stall  (res_stall),
	.res_item   (res_item)
);
